FILE: design/hsv_to_rgb_converter_unit_defines.svh
// Assertion macros shared by the color converter RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HSVRGB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hsvrgb assertion failed");
`define HSVRGB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hsvrgb assertion failed");
`else
`define HSVRGB_ASSERT(lbl, clk, rst_n, prop)
`define HSVRGB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: design/hsvrgb_pkg.sv
// Constants and types for the HSV to RGB converter pipeline.
// No dependencies.
package hsvrgb_pkg;

  localparam int unsigned HueW = 9;
  localparam int unsigned ChanW = 8;
  localparam int unsigned FracW = 6;
  localparam int unsigned NumStages = 5;

  localparam logic [HueW-1:0] HueFullTurn = 9'd360;
  localparam logic [HueW-1:0] HueSector = 9'd60;
  localparam logic [FracW-1:0] SectorSpan = 6'd60;

  // floor(p / 60) == (p * RecipSixty) >> RecipShift for p <= 255 * 60
  localparam logic [14:0] RecipSixty = 15'd17477;
  localparam int unsigned RecipShift = 20;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [FracW-1:0] frac_t;
  typedef logic [2:0] sector_t;

  localparam sector_t SecRed = 3'd0;
  localparam sector_t SecYellow = 3'd1;
  localparam sector_t SecGreen = 3'd2;
  localparam sector_t SecCyan = 3'd3;
  localparam sector_t SecBlue = 3'd4;
  localparam sector_t SecMagenta = 3'd5;

  typedef struct packed {
    sector_t sector;
    chan_t chroma;
    frac_t term;
    chan_t val;
  } front_t;

endpackage

FILE: design/hsvrgb_front.sv
// Front stages: hue wrap, sector split, V*S product, chroma and X weight.
// Depends on hsvrgb_pkg.
module hsvrgb_front import hsvrgb_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [HueW-1:0]  hue_degrees_i,
  input  chan_t            saturation_i,
  input  chan_t            brightness_i,
  output front_t           front_o
);

  logic [HueW-1:0] hue_w;
  logic [HueW-1:0] base;
  sector_t sector_d, sector_q;
  frac_t frac_d, frac_q;
  logic [15:0] prod_d, prod_q;
  chan_t val_q;
  logic [16:0] div_sum;
  logic [HueW-1:0] diff;
  front_t front_d, front_q;

  always_comb begin
    hue_w = (hue_degrees_i >= HueFullTurn) ? hue_degrees_i - HueFullTurn : hue_degrees_i;
    if (hue_w >= 9'd300) begin
      sector_d = SecMagenta;
      base = 9'd300;
    end else if (hue_w >= 9'd240) begin
      sector_d = SecBlue;
      base = 9'd240;
    end else if (hue_w >= 9'd180) begin
      sector_d = SecCyan;
      base = 9'd180;
    end else if (hue_w >= 9'd120) begin
      sector_d = SecGreen;
      base = 9'd120;
    end else if (hue_w >= HueSector) begin
      sector_d = SecYellow;
      base = HueSector;
    end else begin
      sector_d = SecRed;
      base = '0;
    end
    diff = hue_w - base;
    frac_d = diff[FracW-1:0];
    prod_d = 16'(brightness_i) * 16'(saturation_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sector_q <= sector_d;
      frac_q <= frac_d;
      prod_q <= prod_d;
      val_q <= brightness_i;
    end
  end

  // floor(p / 255) for p < 65535
  always_comb begin
    div_sum = 17'(prod_q) + 17'(prod_q[15:8]) + 17'd1;
    front_d.sector = sector_q;
    front_d.chroma = div_sum[15:8];
    front_d.term = sector_q[0] ? SectorSpan - frac_q : frac_q;
    front_d.val = val_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

FILE: design/hsvrgb_back.sv
// Back stages: X product, divide by 60, channel placement plus offset.
// Depends on hsvrgb_pkg.
module hsvrgb_back import hsvrgb_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  front_t front_i,
  output chan_t  red_o,
  output chan_t  green_o,
  output chan_t  blue_o
);

  logic [13:0] xprod_q;
  chan_t chroma3_q, offs3_q, chroma4_q, offs4_q, xterm_q;
  sector_t sector3_q, sector4_q;
  logic [28:0] recip_prod;
  chan_t r_pl, g_pl, b_pl;
  chan_t red_d, green_d, blue_d, red_q, green_q, blue_q;
  logic [ChanW:0] r_sum, g_sum, b_sum;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xprod_q <= 14'(front_i.chroma) * 14'(front_i.term);
      chroma3_q <= front_i.chroma;
      offs3_q <= front_i.val - front_i.chroma;
      sector3_q <= front_i.sector;
    end
  end

  assign recip_prod = 29'(xprod_q) * 29'(RecipSixty);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xterm_q <= recip_prod[RecipShift +: ChanW];
      chroma4_q <= chroma3_q;
      offs4_q <= offs3_q;
      sector4_q <= sector3_q;
    end
  end

  always_comb begin
    case (sector4_q)
      SecRed: begin
        r_pl = chroma4_q; g_pl = xterm_q; b_pl = '0;
      end
      SecYellow: begin
        r_pl = xterm_q; g_pl = chroma4_q; b_pl = '0;
      end
      SecGreen: begin
        r_pl = '0; g_pl = chroma4_q; b_pl = xterm_q;
      end
      SecCyan: begin
        r_pl = '0; g_pl = xterm_q; b_pl = chroma4_q;
      end
      SecBlue: begin
        r_pl = xterm_q; g_pl = '0; b_pl = chroma4_q;
      end
      default: begin
        r_pl = chroma4_q; g_pl = '0; b_pl = xterm_q;
      end
    endcase
    r_sum = {1'b0, r_pl} + {1'b0, offs4_q};
    g_sum = {1'b0, g_pl} + {1'b0, offs4_q};
    b_sum = {1'b0, b_pl} + {1'b0, offs4_q};
    red_d = r_sum[ChanW] ? '1 : r_sum[ChanW-1:0];
    green_d = g_sum[ChanW] ? '1 : g_sum[ChanW-1:0];
    blue_d = b_sum[ChanW] ? '1 : b_sum[ChanW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q <= red_d;
      green_q <= green_d;
      blue_q <= blue_d;
    end
  end

  assign red_o = red_q;
  assign green_o = green_q;
  assign blue_o = blue_q;

endmodule

FILE: design/hsv_to_rgb_converter_unit.sv
// HSV to RGB converter, five register stages; depends on hsvrgb_pkg,
// hsvrgb_front, hsvrgb_back and the assertion macro header.
// A transfer passes every register stage in order before output valid rises.
// Throughput: one pixel per cycle; the whole pipe advances as one, so a
// stall at the output holds every stage. Reset clears only the valid bits.
`include "hsv_to_rgb_converter_unit_defines.svh"
module hsv_to_rgb_converter_unit import hsvrgb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [HueW-1:0] hue_degrees_i,
  input  chan_t           saturation_i,
  input  chan_t           brightness_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output chan_t           red_o,
  output chan_t           green_o,
  output chan_t           blue_o
);

  logic [NumStages-1:0] vld_d, vld_q;
  logic adv;
  front_t front;

  assign adv = !vld_q[NumStages-1] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[NumStages-1];
  assign vld_d = {vld_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  hsvrgb_front u_front (
    .clk_i         (clk_i),
    .en_i          (adv),
    .hue_degrees_i (hue_degrees_i),
    .saturation_i  (saturation_i),
    .brightness_i  (brightness_i),
    .front_o       (front)
  );

  hsvrgb_back u_back (
    .clk_i   (clk_i),
    .en_i    (adv),
    .front_i (front),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  `HSVRGB_ASSERT(a_transfer_enters, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> vld_q[0])
  `HSVRGB_ASSERT(a_stall_freezes, clk_i, rst_ni, !in_ready_o |=> $stable(vld_q))
  `HSVRGB_ASSERT(a_latency, clk_i, rst_ni, ($past(in_valid_i && in_ready_o, 5) && $past(out_ready_i, 1) && $past(out_ready_i, 2) && $past(out_ready_i, 3) && $past(out_ready_i, 4)) |-> out_valid_o)
  `HSVRGB_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for hsv_to_rgb_converter_unit: directed table, then random pixels.
// Depends on hsvrgb_pkg and the converter RTL; expects fixed or predicted RGB results, compares per channel.
`timescale 1ns / 1ps
module tb_top;
  import hsvrgb_pkg::*;

  localparam int unsigned NumRandom = 1000;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    chan_t sat;
    chan_t val;
    logic fixed;
    rgb_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [HueW-1:0] hue_degrees_i = '0;
  chan_t saturation_i = '0;
  chan_t brightness_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  chan_t red_o, green_o, blue_o;

  rgb_t rgb_expected_q[$];
  int unsigned px_sent = 0;
  int unsigned px_checked = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic calm = 1'b0;
  logic stall_hold = 1'b0;
  chan_t edges [4] = '{8'd0, 8'd1, 8'd254, 8'd255};

  // hue, sat, val, fixed expectation, expected rgb
  stim_row_t dir_tab [24] = '{
    '{9'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{9'd60,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{9'd120, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{9'd180, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{9'd240, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{9'd300, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{9'd360, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{9'd420, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{9'd511, 8'd255, 8'd255, 1'b0, '0},
    '{9'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{9'd200, 8'd0,   8'd200, 1'b1, '{8'd200, 8'd200, 8'd200}},
    '{9'd511, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{9'd0,   8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{9'd59,  8'd255, 8'd255, 1'b0, '0},
    '{9'd119, 8'd200, 8'd100, 1'b0, '0},
    '{9'd179, 8'd255, 8'd128, 1'b0, '0},
    '{9'd239, 8'd1,   8'd255, 1'b0, '0},
    '{9'd299, 8'd254, 8'd254, 1'b0, '0},
    '{9'd359, 8'd255, 8'd255, 1'b0, '0},
    '{9'd30,  8'd128, 8'd255, 1'b0, '0},
    '{9'd256, 8'd170, 8'd85,  1'b0, '0},
    '{9'd255, 8'd85,  8'd170, 1'b0, '0},
    '{9'd480, 8'd255, 8'd1,   1'b0, '0},
    '{9'd90,  8'd1,   8'd1,   1'b0, '0}
  };

  hsv_to_rgb_converter_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .hue_degrees_i(hue_degrees_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
             rgb_expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic rgb_t hsv_predict(logic [HueW-1:0] hue, chan_t sat, chan_t val);
    int unsigned h, s, v, sector, frac, chroma, xterm, offs, r, g, b;
    rgb_t res;
    h = 32'(hue);
    s = 32'(sat);
    v = 32'(val);
    if (h >= int'(HueFullTurn)) h = h - int'(HueFullTurn);
    sector = h / int'(HueSector);
    frac = h % int'(HueSector);
    chroma = (v * s) / 255;
    if (sector % 2 == 0) xterm = (chroma * frac) / int'(HueSector);
    else xterm = (chroma * (int'(HueSector) - frac)) / int'(HueSector);
    offs = v - chroma;
    case (sector_t'(sector))
      SecRed: begin
        r = chroma; g = xterm; b = 0;
      end
      SecYellow: begin
        r = xterm; g = chroma; b = 0;
      end
      SecGreen: begin
        r = 0; g = chroma; b = xterm;
      end
      SecCyan: begin
        r = 0; g = xterm; b = chroma;
      end
      SecBlue: begin
        r = xterm; g = 0; b = chroma;
      end
      default: begin
        r = chroma; g = 0; b = xterm;
      end
    endcase
    r = (r + offs > 255) ? 255 : r + offs;
    g = (g + offs > 255) ? 255 : g + offs;
    b = (b + offs > 255) ? 255 : b + offs;
    res.red = chan_t'(r);
    res.green = chan_t'(g);
    res.blue = chan_t'(b);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // one transfer per call; valid stays high until accepted
  task automatic send_pixel(input logic [HueW-1:0] hue, input chan_t sat, input chan_t val,
                            input logic fixed, input rgb_t want);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    hue_degrees_i <= hue;
    saturation_i <= sat;
    brightness_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    rgb_expected_q = {rgb_expected_q, (fixed ? want : hsv_predict(hue, sat, val))};
    px_sent++;
  endtask

  always @(posedge clk_i) begin
    if (stall_hold) begin
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rgb_expected_q.size() == 0) begin
        report_mismatch("unexpected transfer", int'({red_o, green_o, blue_o}), 0);
      end else begin
        want = rgb_expected_q.pop_front();
        if (red_o !== want.red) report_mismatch("red", int'(red_o), int'(want.red));
        if (green_o !== want.green) report_mismatch("green", int'(green_o), int'(want.green));
        if (blue_o !== want.blue) report_mismatch("blue", int'(blue_o), int'(want.blue));
        px_checked++;
      end
    end
  end

  // receiver back-pressure: hold ready low long enough to fill the pipe
  initial begin
    wait (px_sent >= 300);
    @(posedge clk_i);
    stall_hold <= 1'b1;
    for (int i = 0; i < HoldCycles; i++) @(posedge clk_i);
    stall_hold <= 1'b0;
  end

  initial begin
    logic [HueW-1:0] hue;
    chan_t sat, val;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_pixel(dir_tab[i].hue, dir_tab[i].sat, dir_tab[i].val, dir_tab[i].fixed,
                 dir_tab[i].want);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 600) calm <= 1'b1;
      if (n == 800) calm <= 1'b0;
      if ($urandom_range(0, 99) < 70) begin
        hue = HueW'($urandom_range(0, 511));
        sat = chan_t'($urandom_range(0, 255));
        val = chan_t'($urandom_range(0, 255));
      end else begin
        // near sector boundaries, including the wrapped range
        hue = HueW'(60 * $urandom_range(0, 8) + $urandom_range(0, 2));
        if ($urandom_range(0, 1)) hue = hue - 1'b1;
        sat = $urandom_range(0, 1) ? edges[$urandom_range(0, 3)]
                                   : chan_t'($urandom_range(0, 255));
        val = $urandom_range(0, 1) ? edges[$urandom_range(0, 3)]
                                   : chan_t'($urandom_range(0, 255));
      end
      send_pixel(hue, sat, val, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (rgb_expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d pixels sent (%0d directed), %0d results checked, %0d mismatches",
             px_sent, $size(dir_tab), px_checked, err_cnt);
    $display("covered hue wrap, sector edges, zero saturation and a %0d-cycle output stall",
             HoldCycles);
    if (err_cnt == 0 && rgb_expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
